// ----- rtl/core/hlfa_pkg.sv -----
// Shared types and codes for the hole list fit allocator.
// No dependencies; imported by hlfa_mem, hlfa_pick and the top level.
`timescale 1ns / 1ps

package hlfa_pkg;

  // one hole table entry
  typedef struct packed {
    logic [15:0] size;
    logic [31:0] offset;
  } hole_t;

  // running choice of the fit search
  typedef struct packed {
    logic  found;
    hole_t hole;
  } pick_t;

  // fit policy codes held in the fit_mode register
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // item operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // register index of fit_mode, taken from paddr word bits
  localparam logic REG_FIT_MODE = 1'b0;

endpackage

// ----- rtl/core/hlfa_mem.sv -----
// Hole table storage: one write port, one read port, registered read data.
// Depends on hlfa_pkg for the entry type.
`timescale 1ns / 1ps

module hlfa_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  hlfa_pkg::hole_t  wdata,
  input  logic [AW-1:0]    raddr,
  output hlfa_pkg::hole_t  rdata
);
  import hlfa_pkg::*;

  hole_t mem [DEPTH];
  hole_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/hlfa_pick.sv -----
// Fit search unit: looks at one hole per cycle while vld is high and keeps the chosen one.
// Depends on hlfa_pkg for the entry type and the fit policy codes.
`timescale 1ns / 1ps

module hlfa_pick #(
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             vld,
  input  logic [AW-1:0]    idx,
  input  hlfa_pkg::hole_t  hole,
  input  logic [15:0]      need,
  input  logic [1:0]       mode,
  output hlfa_pkg::pick_t  pick,
  output logic [AW-1:0]    pick_idx
);
  import hlfa_pkg::*;

  logic          found_r;
  hole_t         hole_r;
  logic [AW-1:0] idx_r;
  logic          fits;
  logic          upd;

  // strict compares keep ties on the earliest entry
  always_comb begin
    fits = (hole.size >= need);
    case (mode)
      FIT_BEST:  upd = fits && (!found_r || (hole.size < hole_r.size));
      FIT_WORST: upd = !found_r || (hole.size > hole_r.size);
      default:   upd = fits && !found_r;
    endcase
  end

  // found flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (clear) begin
      found_r <= 1'b0;
    end else if (vld && upd) begin
      found_r <= 1'b1;
    end
  end

  // chosen entry payload
  always_ff @(posedge clk) begin
    if (vld && upd) begin
      hole_r <= hole;
      idx_r  <= idx;
    end
  end

  assign pick.found = found_r;
  assign pick.hole  = hole_r;
  assign pick_idx   = idx_r;

endmodule

// ----- rtl/core/hole_list_fit_allocator_unit.sv -----
// Hole list fit allocator, top level: APB register, item control, hole table.
// Depends on hlfa_pkg, hlfa_mem and hlfa_pick.
`timescale 1ns / 1ps

// One item is handled at a time. A free (and an allocate with an empty table)
// goes straight to the result, and the next item can be taken in the same
// cycle as the result shows. An allocate with N holes held reads all N
// entries and then decides; when nothing fits, it loads the result. When a
// hole fits at index k, it moves the N-1-k entries above it down one slot,
// writes the leftover and loads the result. Each scanned or moved entry
// costs one read of the single read port of the hole table. The result waits
// in an output register, so the next item is taken while it is still
// unclaimed. fit_mode lies at byte address 0 (0 first fit, 1 best fit,
// 2 worst fit; 3 acts as first fit).
module hole_list_fit_allocator_unit #(
  parameter int HOLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_size,
  input  logic [31:0] in_free_offset,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_grant_offset,
  output logic        out_from_end,
  output logic        out_status,
  output logic [6:0]  out_hole_count,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hlfa_pkg::*;

  localparam int AW = (HOLE_DEPTH > 1) ? $clog2(HOLE_DEPTH) : 1;
  localparam int CW = $clog2(HOLE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_LEFT   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    mode_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [31:0]   end_r, end_nxt;
  logic [15:0]   size_r, size_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic [AW-1:0] rd_idx_r;
  logic          sh_vld_r, sh_vld_nxt;
  logic [AW-1:0] sh_wa_r, sh_wa_nxt;
  hole_t         left_r, left_nxt;
  logic [31:0]   res_grant_r, res_grant_nxt;
  logic          res_end_r, res_end_nxt;
  logic          res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_grant_r;
  logic          out_end_r;
  logic          out_status_r;
  logic [6:0]    out_count_r;

  logic          accept;
  logic          cfg_wr;
  logic          issuing;
  logic          fits;
  logic          out_load;
  logic          pick_clear;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  hole_t         mem_wdata;
  hole_t         rd_data;
  pick_t         pick;
  logic [AW-1:0] pick_idx;
  logic [CW+6:0] count_wide;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= FIT_FIRST;
    end else if (cfg_wr && (paddr[2] == REG_FIT_MODE)) begin
      mode_r <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == REG_FIT_MODE) ? {30'd0, mode_r} : 32'd0;

  // handshake
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign issuing  = (ptr_r < used_r);
  assign fits     = pick.found && (pick.hole.size >= size_r);

  // control sequencer
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    end_nxt        = end_r;
    size_nxt       = size_r;
    ptr_nxt        = ptr_r;
    rd_vld_nxt     = 1'b0;
    rd_last_nxt    = 1'b0;
    sh_vld_nxt     = 1'b0;
    sh_wa_nxt      = sh_wa_r;
    left_nxt       = left_r;
    res_grant_nxt  = res_grant_r;
    res_end_nxt    = res_end_r;
    res_status_nxt = res_status_r;
    pick_clear     = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = used_r[AW-1:0];
    mem_wdata      = '{size: in_size, offset: in_free_offset};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          size_nxt       = in_size;
          res_grant_nxt  = 32'd0;
          res_end_nxt    = 1'b0;
          res_status_nxt = ST_OK;
          if (in_op == OP_FREE) begin
            state_nxt = S_DONE;
            if (used_r >= CW'(HOLE_DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we   = 1'b1;
              used_nxt = used_r + CW'(1);
            end
          end else if (used_r == '0) begin
            state_nxt     = S_DONE;
            res_grant_nxt = end_r;
            res_end_nxt   = 1'b1;
            end_nxt       = end_r + {16'd0, in_size};
          end else begin
            state_nxt  = S_SCAN;
            ptr_nxt    = '0;
            pick_clear = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (issuing) begin
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (ptr_r == (used_r - CW'(1)));
          ptr_nxt     = ptr_r + CW'(1);
        end
        if (rd_last_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (fits) begin
          res_grant_nxt = pick.hole.offset;
          left_nxt      = '{size:   pick.hole.size - size_r,
                            offset: pick.hole.offset + {16'd0, size_r}};
          ptr_nxt       = CW'(pick_idx) + CW'(1);
          state_nxt     = S_SHIFT;
        end else begin
          res_grant_nxt = end_r;
          res_end_nxt   = 1'b1;
          end_nxt       = end_r + {16'd0, size_r};
          state_nxt     = S_DONE;
        end
      end
      S_SHIFT: begin
        // read entry j+1 now, write it to slot j in the next cycle
        if (issuing) begin
          sh_vld_nxt = 1'b1;
          sh_wa_nxt  = ptr_r[AW-1:0] - AW'(1);
          ptr_nxt    = ptr_r + CW'(1);
        end else if (!sh_vld_r) begin
          state_nxt = S_LEFT;
        end
        if (sh_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = sh_wa_r;
          mem_wdata = rd_data;
        end
      end
      S_LEFT: begin
        // leftover goes to the last slot, count is unchanged
        mem_we    = 1'b1;
        mem_waddr = used_r[AW-1:0] - AW'(1);
        mem_wdata = left_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      end_r     <= 32'd0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      sh_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      end_r     <= end_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
      sh_vld_r  <= sh_vld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    ptr_r        <= ptr_nxt;
    rd_idx_r     <= ptr_r[AW-1:0];
    sh_wa_r      <= sh_wa_nxt;
    left_r       <= left_nxt;
    res_grant_r  <= res_grant_nxt;
    res_end_r    <= res_end_nxt;
    res_status_r <= res_status_nxt;
  end

  // output register
  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);
  assign count_wide    = (CW + 7)'(used_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_grant_r  <= res_grant_r;
      out_end_r    <= res_end_r;
      out_status_r <= res_status_r;
      out_count_r  <= count_wide[6:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_grant_offset = out_grant_r;
  assign out_from_end     = out_end_r;
  assign out_status       = out_status_r;
  assign out_hole_count   = out_count_r;

  // hole table
  hlfa_mem #(
    .DEPTH (HOLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (ptr_r[AW-1:0]),
    .rdata (rd_data)
  );

  // fit search
  hlfa_pick #(
    .AW (AW)
  ) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (pick_clear),
    .vld      (rd_vld_r),
    .idx      (rd_idx_r),
    .hole     (rd_data),
    .need     (size_r),
    .mode     (mode_r),
    .pick     (pick),
    .pick_idx (pick_idx)
  );

endmodule

// ----- rtl/core/hlfa_checker.sv -----
// Port level checks for the hole list fit allocator, bound to the top level.
// Depends on hole_list_fit_allocator_unit for the bind target.
`timescale 1ns / 1ps

module hlfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_grant_offset,
  input logic        out_from_end,
  input logic        out_status
);

  // one item in flight: acceptance closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_grant_offset)
      && $stable(out_from_end) && $stable(out_status))
    else $error("result changed while stalled");

  // a full table error only comes from a free, which grants nothing
  a_full_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_from_end && (out_grant_offset == 32'd0))
    else $error("table full status with a grant");

  // no result while an item is still being taken with nothing before it
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_ready |=> !out_valid)
    else $error("result appeared in the cycle after acceptance");

endmodule

bind hole_list_fit_allocator_unit hlfa_checker u_hlfa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_grant_offset (out_grant_offset),
  .out_from_end     (out_from_end),
  .out_status       (out_status)
);
